[rtl/lrl_pkg.sv]
// Shared types and codes for the LRU replacement list.
`timescale 1ns / 1ps

package lrl_pkg;

  localparam int SLOT_W = 10;
  localparam int CNT_W  = 7;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_HIT    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EVICT  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_RELINK,
    S_EV_DO,
    S_EV_RD
  } seq_state_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [SLOT_W-1:0] slot_id;
    logic [CNT_W-1:0]  evict_count;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] evicted_slot;
    logic [STAT_W-1:0] status;
    logic              last;
  } res_t;

  // Write strobes from the sequencer to the link tables
  typedef struct packed {
    logic nxt_we;
    logic prv_we;
    logic pres_we;
    logic pres_wd;
  } tbl_wr_t;

endpackage

[rtl/lrl_if.sv]
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps

interface lrl_req_if;
  import lrl_pkg::*;
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [SLOT_W-1:0]   slot_id;
  logic [CNT_W-1:0]    evict_count;

  modport source (output valid, req_type, slot_id, evict_count, input ready);
  modport sink   (input valid, req_type, slot_id, evict_count, output ready);
endinterface

interface lrl_res_if;
  import lrl_pkg::*;
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   evicted_slot;
  logic [STAT_W-1:0]   status;
  logic                last;

  modport source (output valid, evicted_slot, status, last, input ready);
  modport sink   (input valid, evicted_slot, status, last, output ready);
endinterface

[rtl/lru_replacement_list_top.sv]
// Top level of the LRU replacement list: sequencer, link tables and output register.
`timescale 1ns / 1ps

// Insert or hit: accept, look-up and decide states, then the result; a mid-list slot adds a relink state.
// Evict of n slots: one link-table read and one update per victim, in alternating states;
// the single read port on the back-link table sets this pace.
// One request at a time; in_req.ready is low until its final beat is in the output register.
// After reset a clearing pass zeroes the presence bits, with ready low throughout.
// Results wait in a one-deep output register while the next request is accepted.

module lru_replacement_list_top
  import lrl_pkg::*;
#(
  parameter int NUM_SLOTS = 1024,
  parameter int MAX_BATCH = 64
) (
  input  logic clk,
  input  logic rst_n,
  lrl_req_if.sink   in_req,
  lrl_res_if.source out_res
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  req_t          in_beat;
  res_t          res;
  logic          res_push;
  logic          res_free;
  tbl_wr_t       wr;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] nxt_waddr, nxt_wdata;
  logic [SW-1:0] prv_waddr, prv_wdata;
  logic [SW-1:0] pres_waddr;
  logic [SW-1:0] nxt_q, prv_q;
  logic          pres_q;

  logic          out_valid_r;
  res_t          out_beat_r;

  assign in_beat.req_type    = in_req.req_type;
  assign in_beat.slot_id     = in_req.slot_id;
  assign in_beat.evict_count = in_req.evict_count;

  // Room for a new beat when empty or when the held beat leaves this cycle
  assign res_free = !out_valid_r || out_res.ready;

  lrl_seq #(
    .NUM_SLOTS (NUM_SLOTS),
    .MAX_BATCH (MAX_BATCH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_ready   (in_req.ready),
    .in_beat    (in_beat),
    .res_free   (res_free),
    .res_push   (res_push),
    .res        (res),
    .wr         (wr),
    .rd_addr    (rd_addr),
    .nxt_waddr  (nxt_waddr),
    .nxt_wdata  (nxt_wdata),
    .prv_waddr  (prv_waddr),
    .prv_wdata  (prv_wdata),
    .pres_waddr (pres_waddr),
    .nxt_q      (nxt_q),
    .prv_q      (prv_q),
    .pres_q     (pres_q)
  );

  lrl_link_ram #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ram (
    .clk        (clk),
    .wr         (wr),
    .rd_addr    (rd_addr),
    .nxt_waddr  (nxt_waddr),
    .nxt_wdata  (nxt_wdata),
    .prv_waddr  (prv_waddr),
    .prv_wdata  (prv_wdata),
    .pres_waddr (pres_waddr),
    .nxt_q      (nxt_q),
    .prv_q      (prv_q),
    .pres_q     (pres_q)
  );

  // Output register: load on push, drop the valid flag once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload holds while stalled
  always_ff @(posedge clk) begin
    if (res_push) begin
      out_beat_r <= res;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.evicted_slot = out_beat_r.evicted_slot;
  assign out_res.status       = out_beat_r.status;
  assign out_res.last         = out_beat_r.last;

endmodule

[rtl/lrl_link_ram.sv]
// Slot-indexed link tables and presence bits, one write and one read port each.
`timescale 1ns / 1ps

module lrl_link_ram
  import lrl_pkg::*;
#(
  parameter int NUM_SLOTS = 1024,
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic          clk,
  input  tbl_wr_t       wr,
  input  logic [SW-1:0] rd_addr,
  input  logic [SW-1:0] nxt_waddr,
  input  logic [SW-1:0] nxt_wdata,
  input  logic [SW-1:0] prv_waddr,
  input  logic [SW-1:0] prv_wdata,
  input  logic [SW-1:0] pres_waddr,
  output logic [SW-1:0] nxt_q,
  output logic [SW-1:0] prv_q,
  output logic          pres_q
);

  logic [SW-1:0] nxt_mem  [NUM_SLOTS];
  logic [SW-1:0] prv_mem  [NUM_SLOTS];
  logic          pres_mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.nxt_we) begin
      nxt_mem[nxt_waddr] <= nxt_wdata;
    end
    nxt_q <= nxt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.prv_we) begin
      prv_mem[prv_waddr] <= prv_wdata;
    end
    prv_q <= prv_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.pres_we) begin
      pres_mem[pres_waddr] <= wr.pres_wd;
    end
    pres_q <= pres_mem[rd_addr];
  end

endmodule

[rtl/lrl_seq.sv]
// Sequencer: walks link tables for insert, hit, evict; one step per cycle unless stalled.
`timescale 1ns / 1ps

module lrl_seq
  import lrl_pkg::*;
#(
  parameter int NUM_SLOTS = 1024,
  parameter int MAX_BATCH = 64,
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  req_t          in_beat,
  input  logic          res_free,
  output logic          res_push,
  output res_t          res,
  output tbl_wr_t       wr,
  output logic [SW-1:0] rd_addr,
  output logic [SW-1:0] nxt_waddr,
  output logic [SW-1:0] nxt_wdata,
  output logic [SW-1:0] prv_waddr,
  output logic [SW-1:0] prv_wdata,
  output logic [SW-1:0] pres_waddr,
  input  logic [SW-1:0] nxt_q,
  input  logic [SW-1:0] prv_q,
  input  logic          pres_q
);

  localparam logic [CNT_W-1:0] BATCH_MAX = CNT_W'(MAX_BATCH);
  localparam logic [SW-1:0]    LAST_IDX  = SW'(NUM_SLOTS - 1);

  seq_state_t        state_r, state_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [SW-1:0]     head_r, head_nxt;
  logic [SW-1:0]     tail_r, tail_nxt;
  logic              nonempty_r, nonempty_nxt;
  logic [SW-1:0]     clr_r, clr_nxt;

  logic [SW-1:0]     s_idx;
  logic              slot_ok;
  logic              s_at_head;
  logic              s_at_tail;
  logic              one_left;

  assign s_idx     = SW'(slot_r);
  assign slot_ok   = ({7'd0, slot_r} < 17'(NUM_SLOTS));
  assign s_at_head = (s_idx == head_r);
  assign s_at_tail = (s_idx == tail_r);
  assign one_left  = (head_r == tail_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      nonempty_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      nonempty_r <= nonempty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    slot_r <= slot_nxt;
    rem_r  <= rem_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    slot_nxt     = slot_r;
    rem_nxt      = rem_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    nonempty_nxt = nonempty_r;
    clr_nxt      = clr_r;
    in_ready     = 1'b0;
    res_push     = 1'b0;
    res          = '0;
    res.status   = ST_DONE;
    res.last     = 1'b1;
    wr           = '0;
    rd_addr      = s_idx;
    nxt_waddr    = s_idx;
    nxt_wdata    = head_r;
    prv_waddr    = head_r;
    prv_wdata    = s_idx;
    pres_waddr   = s_idx;

    case (state_r)
      S_CLEAR: begin
        wr.pres_we = 1'b1;
        wr.pres_wd = 1'b0;
        pres_waddr = clr_r;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_beat.req_type;
          slot_nxt  = in_beat.slot_id;
          rem_nxt   = (in_beat.evict_count > BATCH_MAX) ? BATCH_MAX : in_beat.evict_count;
          state_nxt = S_LOOK;
        end
      end

      S_LOOK: begin
        if (req_r == REQ_EVICT) begin
          // fetch the tail's back link ahead of the first victim
          rd_addr = tail_r;
          if (rem_r != '0) begin
            state_nxt = S_EV_DO;
          end else if (res_free) begin
            res_push  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (req_r == REQ_INSERT || req_r == REQ_HIT) begin
          state_nxt = S_DECIDE;
        end else if (res_free) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_DECIDE: begin
        if (!slot_ok || (!pres_q && req_r == REQ_HIT)) begin
          if (req_r == REQ_HIT) begin
            res.status = ST_ABSENT;
          end
          if (res_free) begin
            res_push  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (!pres_q) begin
          if (res_free) begin
            wr.pres_we = 1'b1;
            wr.pres_wd = 1'b1;
            if (!nonempty_r) begin
              tail_nxt     = s_idx;
              nonempty_nxt = 1'b1;
            end else begin
              wr.nxt_we = 1'b1;
              wr.prv_we = 1'b1;
            end
            head_nxt  = s_idx;
            res_push  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (s_at_head) begin
          // already most recent: every link stays as it was
          if (res_free) begin
            res_push  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (s_at_tail) begin
          if (res_free) begin
            tail_nxt  = prv_q;
            wr.nxt_we = 1'b1;
            wr.prv_we = 1'b1;
            head_nxt  = s_idx;
            res_push  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          // bridge the neighbors, then relink at the head in S_RELINK once the output has room
          wr.nxt_we = 1'b1;
          nxt_waddr = prv_q;
          nxt_wdata = nxt_q;
          wr.prv_we = 1'b1;
          prv_waddr = nxt_q;
          prv_wdata = prv_q;
          state_nxt = S_RELINK;
        end
      end

      S_RELINK: begin
        if (res_free) begin
          wr.nxt_we = 1'b1;
          wr.prv_we = 1'b1;
          head_nxt  = s_idx;
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_EV_DO: begin
        rd_addr = tail_r;
        if (res_free) begin
          res_push = 1'b1;
          if (!nonempty_r) begin
            res.status = ST_EMPTY;
            state_nxt  = S_IDLE;
          end else begin
            wr.pres_we       = 1'b1;
            wr.pres_wd       = 1'b0;
            pres_waddr       = tail_r;
            res.evicted_slot = SLOT_W'(tail_r);
            res.last         = (rem_r == CNT_W'(1));
            if (one_left) begin
              nonempty_nxt = 1'b0;
              head_nxt     = '0;
              tail_nxt     = '0;
            end else begin
              tail_nxt = prv_q;
            end
            rem_nxt   = rem_r - 1'b1;
            state_nxt = (rem_r == CNT_W'(1)) ? S_IDLE : S_EV_RD;
          end
        end
      end

      S_EV_RD: begin
        rd_addr   = tail_r;
        state_nxt = S_EV_DO;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_no_push_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !res_push && !in_ready)
    else $error("result or accept during clearing pass");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> res_free)
    else $error("result pushed into a full output register");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res.status == ST_EMPTY |-> res.last && res.evicted_slot == '0)
    else $error("empty-list result not final or carries a slot");

  a_empty_ends_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !nonempty_r |-> head_r == '0 && tail_r == '0)
    else $error("empty list with stale end pointers");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res.last |=> state_r == S_IDLE)
    else $error("sequencer busy after final result");

endmodule

[sim/tb.sv]
// Self-checking testbench for the LRU replacement list top level.
`timescale 1ns / 1ps

module tb;
  import lrl_pkg::*;

  localparam int SLOTS       = 1024;
  localparam int BATCH_MAX   = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 2 * BATCH_MAX + 16;

  // Unused request code: the block answers it with a plain done beat
  localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  lrl_req_if in_req ();
  lrl_res_if out_res ();

  lru_replacement_list_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  // 2 ns period: one delay high, one delay low
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // LRU order mirror: own copy of the link tables, presence bits and the ends.
  // ---------------------------------------------------------------------------
  logic [SLOT_W-1:0] link_next [SLOTS];
  logic [SLOT_W-1:0] link_prev [SLOTS];
  bit                on_list   [SLOTS];
  logic [SLOT_W-1:0] lru_head;
  logic [SLOT_W-1:0] lru_tail;
  bit                list_live;
  int                list_len;

  // Beats the block still owes us, oldest first
  res_t pending_beats [$];

  int send_idle_pct;
  int recv_stall_pct;

  int items_sent;
  int beats_seen;
  int slots_evicted;
  int empty_reports;
  int absent_reports;
  int mismatches;
  int cycles;

  // Detach a slot that is on the list
  function automatic void unlink_slot(logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] nx;
    logic [SLOT_W-1:0] pv;
    nx = link_next[s];
    pv = link_prev[s];
    if (s == lru_head && s == lru_tail) begin
      list_live = 1'b0;
      lru_head  = '0;
      lru_tail  = '0;
    end else if (s == lru_head) begin
      lru_head = nx;
    end else if (s == lru_tail) begin
      lru_tail = pv;
    end else begin
      link_next[pv] = nx;
      link_prev[nx] = pv;
    end
    on_list[s] = 1'b0;
    list_len--;
  endfunction

  // Attach a slot that is off the list at the most recently used end
  function automatic void push_head(logic [SLOT_W-1:0] s);
    if (!list_live) begin
      lru_head  = s;
      lru_tail  = s;
      list_live = 1'b1;
    end else begin
      link_next[s]        = lru_head;
      link_prev[lru_head] = s;
      lru_head            = s;
    end
    on_list[s] = 1'b1;
    list_len++;
  endfunction

  function automatic res_t make_beat(logic [SLOT_W-1:0] slot, logic [STAT_W-1:0] st,
                                     logic lst);
    res_t b;
    b.evicted_slot = slot;
    b.status       = st;
    b.last         = lst;
    return b;
  endfunction

  // Apply one accepted request to the mirror and queue the beats it causes
  function automatic void predict_request(req_t r);
    logic [SLOT_W-1:0] s;
    logic [STAT_W-1:0] st;
    logic [SLOT_W-1:0] victim;
    int                n;
    s = r.slot_id;
    case (r.req_type)
      REQ_INSERT, REQ_HIT: begin
        st = ST_DONE;
        if (on_list[s]) begin
          // insert of a slot already present behaves as a hit
          unlink_slot(s);
          push_head(s);
        end else if (r.req_type == REQ_INSERT) begin
          push_head(s);
        end else begin
          st = ST_ABSENT;
          absent_reports++;
        end
        pending_beats.push_back(make_beat('0, st, 1'b1));
      end
      REQ_EVICT: begin
        n = r.evict_count;
        if (n > BATCH_MAX) n = BATCH_MAX;
        if (n == 0) begin
          pending_beats.push_back(make_beat('0, ST_DONE, 1'b1));
        end else begin
          for (int i = 0; i < n; i++) begin
            if (!list_live) begin
              // ran dry before the count was reached
              pending_beats.push_back(make_beat('0, ST_EMPTY, 1'b1));
              empty_reports++;
              break;
            end
            victim = lru_tail;
            unlink_slot(victim);
            slots_evicted++;
            pending_beats.push_back(make_beat(victim, ST_DONE, (i + 1 == n)));
          end
        end
      end
      default: begin
        pending_beats.push_back(make_beat('0, ST_DONE, 1'b1));
      end
    endcase
  endfunction

  // Pick a slot currently on the list by walking from the head
  function automatic logic [SLOT_W-1:0] pick_listed_slot();
    logic [SLOT_W-1:0] s;
    int                steps;
    s     = lru_head;
    steps = $urandom_range(0, list_len - 1);
    for (int i = 0; i < steps; i++) s = link_next[s];
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Send one request beat; valid stays high afterwards unless the next one idles
  task automatic send_req(input req_t r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_req.valid       <= 1'b1;
    in_req.req_type    <= r.req_type;
    in_req.slot_id     <= r.slot_id;
    in_req.evict_count <= r.evict_count;
    do @(posedge clk); while (!in_req.ready);
    predict_request(r);
    items_sent++;
  endtask

  task automatic send_fields(logic [REQ_W-1:0] op, logic [SLOT_W-1:0] s,
                             logic [CNT_W-1:0] c);
    req_t r;
    r.req_type    = op;
    r.slot_id     = s;
    r.evict_count = c;
    send_req(r);
  endtask

  // Hold valid low until every owed beat has come back
  task automatic wait_drained();
    in_req.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls and the in-order beat check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected beat: slot=%0d status=%0d last=%0b", $realtime,
                   out_res.evicted_slot, out_res.status, out_res.last);
      end else begin
        want = pending_beats.pop_front();
        if (out_res.evicted_slot !== want.evicted_slot || out_res.status !== want.status ||
            out_res.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] beat mismatch: expected slot=%0d status=%0d last=%0b",
                     $realtime, want.evicted_slot, want.status, want.last);
            $display("[%0t]                 got      slot=%0d status=%0d last=%0b",
                     $realtime, out_res.evicted_slot, out_res.status, out_res.last);
          end
        end
      end
    end
  end

  // Watchdog: the clearing pass plus a worst-case run fits well inside this
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycles,
               pending_beats.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner cases on a short list, walked by hand
  task automatic test_directed();
    send_fields(REQ_EVICT,  10'd0,    7'd1);    // evict on an empty list
    send_fields(REQ_HIT,    10'd0,    7'd127);  // hit on an absent slot
    send_fields(REQ_INSERT, 10'd0,    7'd0);
    send_fields(REQ_HIT,    10'd0,    7'd0);    // hit on the only slot
    send_fields(REQ_INSERT, 10'd1023, 7'd127);
    send_fields(REQ_INSERT, 10'd512,  7'd0);    // order now 512, 1023, 0
    send_fields(REQ_INSERT, 10'd0,    7'd0);    // present: tail moves to head
    send_fields(REQ_HIT,    10'd512,  7'd0);    // from the middle
    send_fields(REQ_HIT,    10'd1023, 7'd0);    // from the tail
    send_fields(REQ_HIT,    10'd1023, 7'd0);    // already at head
    send_fields(REQ_HIT,    10'd700,  7'd0);    // absent
    send_fields(REQ_EVICT,  10'd1023, 7'd0);    // zero count
    send_fields(REQ_NOP,    10'd1023, 7'd127);  // unused request code
    send_fields(REQ_EVICT,  10'd341,  7'd127);  // saturates, runs dry after three
    send_fields(REQ_EVICT,  10'd0,    7'd64);   // empty again
    for (int i = 0; i < 5; i++) send_fields(REQ_INSERT, 10'(1 << i), 7'(1 << i));
    send_fields(REQ_EVICT,  10'd682,  7'd5);    // list empties exactly at the count
    send_fields(REQ_INSERT, 10'd3,    7'd0);
    send_fields(REQ_INSERT, 10'd4,    7'd0);
    send_fields(REQ_EVICT,  10'd0,    7'd65);   // saturates
  endtask

  // Mostly well-formed traffic on a live list, with some noise mixed in
  task automatic test_mixed_traffic(int n_items, int idle_pct, int stall_pct);
    req_t r;
    int   roll;
    int   ins_cut;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n_items; k++) begin
      r.req_type    = REQ_INSERT;
      r.slot_id     = 10'($urandom_range(0, SLOTS - 1));
      r.evict_count = 7'($urandom_range(0, 127));
      // keep the list a workable length
      ins_cut = (list_len > 48) ? 20 : 45;
      roll    = $urandom_range(0, 99);
      if (roll < ins_cut) begin
        if (list_len > 0 && $urandom_range(0, 99) < 30) r.slot_id = pick_listed_slot();
      end else if (roll < 78) begin
        r.req_type = REQ_HIT;
        if (list_len > 0 && $urandom_range(0, 99) < 75) r.slot_id = pick_listed_slot();
      end else if (roll < 94) begin
        r.req_type = REQ_EVICT;
        roll = $urandom_range(0, 99);
        if (roll < 70)
          r.evict_count = 7'($urandom_range(1, 6));
        else if (roll < 85)
          r.evict_count = 7'($urandom_range(1, (list_len + 2 > BATCH_MAX) ? BATCH_MAX
                                                                          : list_len + 2));
        else if (roll < 93)
          r.evict_count = 7'($urandom_range(BATCH_MAX + 1, 127));
        else
          r.evict_count = '0;
      end else begin
        r.req_type = REQ_NOP;
      end
      send_req(r);
    end
  endtask

  // Stop sending until the block has nothing left to return, then go on
  task automatic test_drain_pause();
    wait_drained();
    send_fields(REQ_INSERT, 10'($urandom_range(0, SLOTS - 1)), 7'd0);
    send_fields(REQ_EVICT,  10'd0, 7'd2);
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_req.valid       <= 1'b0;
    in_req.req_type    <= REQ_INSERT;
    in_req.slot_id     <= '0;
    in_req.evict_count <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    list_live      = 1'b0;
    list_len       = 0;
    lru_head       = '0;
    lru_tail       = '0;
    for (int i = 0; i < SLOTS; i++) on_list[i] = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // the clearing pass after reset is absorbed by the ready handshake
    test_directed();
    test_mixed_traffic(31, 0, 0);
    test_mixed_traffic(31, 57, 0);
    test_drain_pause();
    test_mixed_traffic(31, 0, 57);
    test_mixed_traffic(31, 21, 21);

    wait_drained();
    repeat (SETTLE) @(posedge clk);

    mismatches += pending_beats.size();
    $display("Covered %0d requests and %0d result beats across four idle/stall mixes.",
             items_sent, beats_seen);
    $display("Evicted %0d slots; %0d empty-list stops and %0d absent-slot hits reported.",
             slots_evicted, empty_reports, absent_reports);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatching, unexpected or missing beats", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
